/* hw/rtl/ifmt_pkg.sv */
// ifmt_pkg: shared types, constants and character helpers for the integer to ASCII formatter.
// No dependencies; imported by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
package ifmt_pkg;

  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 20;
  localparam int DIGITS_W   = 4 * NUM_DIGITS;
  localparam int CNT_W      = 5;
  localparam int ITER_W     = 7;

  localparam logic [CNT_W-1:0]  CNT_DEC    = CNT_W'(NUM_DIGITS);
  localparam logic [CNT_W-1:0]  CNT_HEX32  = CNT_W'(8);
  localparam logic [CNT_W-1:0]  CNT_HEX64  = CNT_W'(16);
  localparam logic [CNT_W-1:0]  CNT_NIL    = CNT_W'(5);
  localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
  localparam logic [ITER_W-1:0] ITER_32    = ITER_W'(32);
  localparam logic [ITER_W-1:0] ITER_64    = ITER_W'(64);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h57;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SDEC32 = 3'd0,
    OP_UDEC32 = 3'd1,
    OP_HEX32  = 3'd2,
    OP_UDEC64 = 3'd3,
    OP_PTR64  = 3'd4,
    OP_CHAR   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    SRC_DIGIT,
    SRC_MINUS,
    SRC_ZERO,
    SRC_X,
    SRC_NIL,
    SRC_RAW
  } src_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic emit;
    src_t src;
    logic last;
  } ifmt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic neg;
    logic zero;
    logic conv_last;
    logic top_zero;
    logic count_one;
    logic out_free;
  } ifmt_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0, d};
    return (d < 4'd10) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
  endfunction

  function automatic logic [CHAR_W-1:0] nil_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0:    c = CH_LPAR;
      3'd1:    c = CH_N;
      3'd2:    c = CH_I;
      3'd3:    c = CH_L;
      default: c = CH_RPAR;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/ifmt_ifs.sv */
// ifmt_in_if and ifmt_out_if: valid/ready channels for operands and emitted characters.
// Depends on ifmt_pkg for field widths.
`timescale 1ns / 1ps
interface ifmt_in_if
  import ifmt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;
  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

interface ifmt_out_if
  import ifmt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last;
  modport source (output valid, ascii_char, last, input ready);
  modport sink (input valid, ascii_char, last, output ready);
endinterface

/* hw/rtl/ifmt_datapath.sv */
// ifmt_datapath: operand load, shift-add BCD conversion, digit shift register and output register.
// Depends on ifmt_pkg and ifmt_out_if; driven by ifmt_controller commands.
`timescale 1ns / 1ps
module ifmt_datapath
  import ifmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [VALUE_W-1:0]  value,
  input  ifmt_cmd_t           cmd,
  output ifmt_status_t        status,
  ifmt_out_if.source          chars
);

  op_t                op;
  logic               neg;
  logic               zero;
  logic [VALUE_W-1:0] bin;
  logic [DIGITS_W-1:0] digits;
  logic [CNT_W-1:0]   count;
  logic [ITER_W-1:0]  iter;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic [31:0]         lo;
  logic [31:0]         mag;
  logic [DIGITS_W-1:0] adj;
  logic [CHAR_W-1:0]   char_next;
  logic [2:0]          nil_idx;
  logic                out_free;

  logic [VALUE_W-1:0]  bin_load;
  logic [ITER_W-1:0]   iter_load;
  logic [DIGITS_W-1:0] digits_load;
  logic [CNT_W-1:0]    count_load;

  assign lo  = value[31:0];
  assign mag = lo[31] ? (~lo + 32'd1) : lo;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? (digits[4*i +: 4] + 4'd3)
                                                   : digits[4*i +: 4];
    end
  end

  assign nil_idx = 3'(CNT_NIL - count);

  always_comb begin
    unique case (cmd.src)
      SRC_DIGIT: char_next = digit_char(digits[DIGITS_W-1 -: 4]);
      SRC_MINUS: char_next = CH_MINUS;
      SRC_ZERO:  char_next = CH_ZERO;
      SRC_X:     char_next = CH_X;
      SRC_NIL:   char_next = nil_char(nil_idx);
      SRC_RAW:   char_next = digits[DIGITS_W-1 -: CHAR_W];
      default:   char_next = CH_ZERO;
    endcase
  end

  always_comb begin
    bin_load    = value;
    iter_load   = ITER_32;
    digits_load = '0;
    count_load  = CNT_DEC;
    unique case (op_t'(opcode))
      OP_SDEC32: bin_load = {mag, 32'b0};
      OP_UDEC32: bin_load = {lo, 32'b0};
      OP_UDEC64: iter_load = ITER_64;
      OP_HEX32: begin
        digits_load = {lo, {(DIGITS_W-32){1'b0}}};
        count_load  = CNT_HEX32;
      end
      OP_PTR64: begin
        digits_load = {value, {(DIGITS_W-VALUE_W){1'b0}}};
        count_load  = (value == '0) ? CNT_NIL : CNT_HEX64;
      end
      OP_CHAR: begin
        digits_load = {value[CHAR_W-1:0], {(DIGITS_W-CHAR_W){1'b0}}};
        count_load  = CNT_ONE;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid || chars.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_t'(opcode);
      neg    <= lo[31];
      zero   <= (value == '0);
      bin    <= bin_load;
      iter   <= iter_load;
      digits <= digits_load;
      count  <= count_load;
    end else if (cmd.step) begin
      digits <= {adj[DIGITS_W-2:0], bin[VALUE_W-1]};
      bin    <= {bin[VALUE_W-2:0], 1'b0};
      iter   <= iter - ITER_W'(1);
    end else if (cmd.shift) begin
      digits <= {digits[DIGITS_W-5:0], 4'b0};
      count  <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= char_next;
      out_last <= cmd.last;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.ascii_char = out_char;
  assign chars.last       = out_last;

  assign status.op        = op;
  assign status.neg       = neg;
  assign status.zero      = zero;
  assign status.conv_last = (iter == ITER_W'(1));
  assign status.top_zero  = (digits[DIGITS_W-1 -: 4] == 4'd0);
  assign status.count_one = (count == CNT_ONE);
  assign status.out_free  = out_free;

endmodule

/* hw/rtl/ifmt_controller.sv */
// ifmt_controller: sequencing state machine for load, conversion, zero stripping and emission.
// Depends on ifmt_pkg; drives ifmt_datapath through ifmt_cmd_t.
`timescale 1ns / 1ps
module ifmt_controller
  import ifmt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ifmt_status_t status,
  output ifmt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MINUS,
    S_PRE0,
    S_PREX,
    S_CONV,
    S_SKIP,
    S_DIGITS,
    S_NIL,
    S_RAW
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '{load: 1'b0, step: 1'b0, shift: 1'b0, emit: 1'b0,
                   src: SRC_DIGIT, last: 1'b0};
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          OP_SDEC32: state_next = status.neg ? S_MINUS : S_CONV;
          OP_UDEC32: state_next = S_CONV;
          OP_UDEC64: state_next = S_CONV;
          OP_HEX32:  state_next = S_SKIP;
          OP_PTR64:  state_next = status.zero ? S_NIL : S_PRE0;
          OP_CHAR:   state_next = S_RAW;
          default:   state_next = S_IDLE;
        endcase
      end
      S_MINUS: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_MINUS;
          state_next = S_CONV;
        end
      end
      S_PRE0: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_ZERO;
          state_next = S_PREX;
        end
      end
      S_PREX: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_X;
          state_next = S_SKIP;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (status.conv_last) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status.top_zero && !status.count_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = S_DIGITS;
        end
      end
      S_DIGITS, S_NIL: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          cmd.src   = (state == S_NIL) ? SRC_NIL : SRC_DIGIT;
          cmd.last  = status.count_one;
          if (status.count_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RAW: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_RAW;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/integer_to_ascii_formatter.sv */
// integer_to_ascii_formatter: one operand in, its ASCII characters out, most significant first.
// Prefix and raw characters are emitted straight after dispatch; decimal first runs 32 or 64 shift-add steps.
// Items are taken one at a time: a new operand is accepted only while the controller is idle,
// and output stalls hold emission; one leading zero stripped per cycle.
// Reset: synchronous active-high rst returns the controller to idle and empties the output.
// Depends on ifmt_pkg, ifmt_ifs, ifmt_controller and ifmt_datapath.
`timescale 1ns / 1ps
module integer_to_ascii_formatter
  import ifmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ifmt_in_if.sink    item,
  ifmt_out_if.source chars
);

  ifmt_cmd_t    cmd;
  ifmt_status_t status;

  ifmt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ifmt_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .opcode (item.opcode),
    .value  (item.value),
    .cmd    (cmd),
    .status (status),
    .chars  (chars)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("input taken while an item is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("character emitted into an occupied output register");

  a_load_xfer: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> item.valid && item.ready)
    else $error("operand loaded without an input transfer");

  a_step_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.emit && !cmd.shift && !item.ready)
    else $error("conversion step overlaps emission or input");

endmodule
